>>> design/assert_macros.svh
// assertion macros shared by the cache rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("invariant check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)

`endif

`endif

>>> design/lkv_pkg.sv
// types, codes and constants of the lru key-value cache
// no dependencies; imported by every module of the block
package lkv_pkg;

  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 4;
  localparam int ENTRIES_DEF = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_WRITE
  } lkv_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic cmp;
    logic fetch;
    logic commit;
  } seq_ctrl_t;

  typedef struct packed {
    logic                     action;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;
    logic signed [DATA_W-1:0] evicted_value;
  } out_item_t;

endpackage

>>> design/lkv_store.sv
// key and value memories: one write port, one registered read port
// depends on lkv_pkg
module lkv_store #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [IW-1:0]                    waddr,
  input  logic signed [lkv_pkg::KEY_W-1:0] wkey,
  input  logic signed [lkv_pkg::DATA_W-1:0] wval,
  input  logic [IW-1:0]                    raddr,
  output logic signed [lkv_pkg::KEY_W-1:0] rkey,
  output logic signed [lkv_pkg::DATA_W-1:0] rval
);
  import lkv_pkg::*;

  logic signed [KEY_W-1:0]  key_mem [ENTRIES];
  logic signed [DATA_W-1:0] val_mem [ENTRIES];
  logic signed [KEY_W-1:0]  rkey_r;
  logic signed [DATA_W-1:0] rval_r;

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    rkey_r <= key_mem[raddr];
    rval_r <= val_mem[raddr];
  end

  assign rkey = rkey_r;
  assign rval = rval_r;

endmodule

>>> design/lkv_seq.sv
// sequencer: walks the entries through the shared compare, then fetch and commit
// depends on lkv_pkg
module lkv_seq #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output lkv_pkg::seq_ctrl_t ctrl,
  output logic [IW-1:0]      scan_idx,
  output logic [IW-1:0]      cmp_idx
);
  import lkv_pkg::*;

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  lkv_state_t    state_r, state_nxt;
  logic [IW-1:0] scan_cnt_r;
  logic [IW-1:0] cmp_idx_r;
  logic          cmp_vld_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_cnt_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        ctrl.accept = start;
      end
      ST_SCAN:  ctrl.scan   = 1'b1;
      ST_DRAIN: ctrl.scan   = 1'b0;
      ST_READ:  ctrl.fetch  = 1'b1;
      ST_WRITE: ctrl.commit = 1'b1;
      default:  busy        = 1'b1;
    endcase
    ctrl.cmp = cmp_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      cmp_idx_r <= scan_cnt_r;
      if (state_r == ST_SCAN) begin
        scan_cnt_r <= (scan_cnt_r == LAST_IDX) ? '0 : scan_cnt_r + 1'b1;
      end else begin
        scan_cnt_r <= '0;
      end
    end
  end

  assign scan_idx = scan_cnt_r;
  assign cmp_idx  = cmp_idx_r;

endmodule

>>> design/lru_key_value_cache.sv
// lru key-value cache: an accepted item is scanned, drained, fetched and committed; out_valid
// rises once the commit is registered; the scan reads one entry a cycle through the single
// compare, a drain state finishes the last compare, a read state fetches the hit or victim data
// and a write state commits; busy stays high until the commit
// result shown for one cycle, no stall; synchronous active-low reset empties cache, capacity 8
// depends on lkv_pkg, lkv_store, lkv_seq and assert_macros.svh
`include "assert_macros.svh"

module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lkv_pkg::in_item_t         in_data,
  output logic                      out_valid,
  output lkv_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = OW + CAP_W;

  seq_ctrl_t ctrl;
  logic [IW-1:0] scan_idx, cmp_idx;

  in_item_t         item_r;
  logic             hit_found_r, free_found_r;
  logic [IW-1:0]    hit_idx_r, free_idx_r, old_idx_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [RW-1:0]    rank_r [ENTRIES];
  logic [RW-1:0]    rank_nxt [ENTRIES];
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;

  logic [IW-1:0]             rd_addr, wr_addr, slot;
  logic                      wr_en, evict, key_match;
  logic signed [KEY_W-1:0]   key_rd;
  logic signed [DATA_W-1:0]  val_rd;
  logic [CW-1:0]             eff_cap, cap_ext;

  lkv_seq #(.ENTRIES(ENTRIES), .IW(IW)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .ctrl     (ctrl),
    .scan_idx (scan_idx),
    .cmp_idx  (cmp_idx)
  );

  lkv_store #(.ENTRIES(ENTRIES), .IW(IW)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wkey  (item_r.key),
    .wval  (item_r.value),
    .raddr (rd_addr),
    .rkey  (key_rd),
    .rval  (val_rd)
  );

  // read port: scan address, then hit entry for a get or victim for a put
  always_comb begin
    if (ctrl.scan) begin
      rd_addr = scan_idx;
    end else if (item_r.action == ACT_GET) begin
      rd_addr = hit_idx_r;
    end else begin
      rd_addr = old_idx_r;
    end
  end

  assign key_match = valid_r[cmp_idx] && (key_rd == item_r.key);

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CW'(cap_r);
    eff_cap = (cap_ext == '0) ? CW'(1) : cap_ext;
    if (eff_cap > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end
  end

  assign evict = (item_r.action == ACT_PUT) && !hit_found_r && (CW'(occ_r) >= eff_cap);

  // lowest free entry once the victim is released
  always_comb begin
    slot = free_idx_r;
    if (evict && (!free_found_r || (old_idx_r < free_idx_r))) begin
      slot = old_idx_r;
    end
  end

  assign wr_en   = ctrl.commit && (item_r.action == ACT_PUT);
  assign wr_addr = hit_found_r ? hit_idx_r : slot;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    if (ctrl.commit) begin
      if (hit_found_r) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] < rank_r[hit_idx_r])) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        rank_nxt[hit_idx_r] = '0;
      end else if (item_r.action == ACT_PUT) begin
        for (int i = 0; i < ENTRIES; i++) begin
          valid_nxt[i] = valid_r[i] && !(evict && (old_idx_r == IW'(i)));
          if (valid_nxt[i]) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        valid_nxt[slot] = 1'b1;
        rank_nxt[slot]  = '0;
        occ_nxt         = evict ? occ_r : occ_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_data_nxt.hit           = hit_found_r;
    out_data_nxt.evicted       = evict;
    out_data_nxt.evicted_key   = evict ? key_rd : '0;
    out_data_nxt.evicted_value = evict ? val_rd : '0;
    if (item_r.action == ACT_PUT) begin
      out_data_nxt.read_value = '0;
    end else if (hit_found_r) begin
      out_data_nxt.read_value = val_rd;
    end else begin
      out_data_nxt.read_value = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      item_r <= in_data;
    end
    if (ctrl.cmp) begin
      if (key_match && !hit_found_r) begin
        hit_idx_r <= cmp_idx;
      end
      if (!valid_r[cmp_idx] && !free_found_r) begin
        free_idx_r <= cmp_idx;
      end
      if (valid_r[cmp_idx] && (OW'(rank_r[cmp_idx]) == OW'(occ_r - 1'b1))) begin
        old_idx_r <= cmp_idx;
      end
    end
    if (ctrl.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      occ_r        <= '0;
      cap_r        <= CAP_RESET;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (ctrl.accept) begin
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else if (ctrl.cmp) begin
        if (key_match) begin
          hit_found_r <= 1'b1;
        end
        if (!valid_r[cmp_idx]) begin
          free_found_r <= 1'b1;
        end
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      valid_r     <= valid_nxt;
      rank_r      <= rank_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= ctrl.commit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_occ_matches_valid, clk, rst_n, $countones(valid_r) == occ_r)
  `ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPLY(a_evict_on_miss, clk, rst_n, out_valid_r && out_data_r.evicted, !out_data_r.hit)

endmodule

>>> dv/lru_key_value_cache_tb.sv
// testbench for lru_key_value_cache: directed and random get/put transfers, capacity sweeps
// holds its own lru predictor in a small checker class; depends on lkv_pkg and the cache rtl
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;

  class lru_cache_checker;
    logic [KEY_W-1:0]  slot_key [SLOTS];
    logic [DATA_W-1:0] slot_val [SLOTS];
    bit                slot_used [SLOTS];
    int                slot_age [SLOTS];
    int                fill;
    logic [CAP_W-1:0]  cap_reg;
    out_item_t         pending_lookups [$];
    int errors, n_get, n_put, n_hit, n_evict, n_cfg;

    function new();
      cap_reg = CAP_RESET;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap_reg = c;
      n_cfg++;
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction

    function void promote(int idx);
      int r0;
      r0 = slot_age[idx];
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_age[i] < r0) slot_age[i]++;
      slot_age[idx] = 0;
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      int idx, old, slot, eff;
      r = '0;
      idx = -1;
      old = -1;
      slot = -1;
      eff = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : int'(cap_reg));
      for (int i = 0; i < SLOTS; i++)
        if (idx < 0 && slot_used[i] && slot_key[i] == it.key) idx = i;
      if (it.action == ACT_GET) begin
        n_get++;
        if (idx >= 0) begin
          r.hit = 1'b1;
          r.read_value = slot_val[idx];
          promote(idx);
        end else begin
          r.read_value = '1;
        end
      end else if (idx >= 0) begin
        n_put++;
        r.hit = 1'b1;
        slot_val[idx] = it.value;
        promote(idx);
      end else begin
        n_put++;
        if (fill >= eff) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && (old < 0 || slot_age[i] > slot_age[old])) old = i;
          if (old >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = slot_key[old];
            r.evicted_value = slot_val[old];
            slot_used[old] = 1'b0;
            slot_age[old] = 0;
            if (fill > 0) fill--;
          end
        end
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i]) slot_age[i]++;
          slot_key[slot] = it.key;
          slot_val[slot] = it.value;
          slot_used[slot] = 1'b1;
          slot_age[slot] = 0;
          fill++;
        end
      end
      if (r.hit) n_hit++;
      if (r.evicted) n_evict++;
      pending_lookups.insert(pending_lookups.size(), r);
    endfunction

    function void check_response(out_item_t got);
      out_item_t exp;
      if (pending_lookups.size() == 0) begin
        $error("unexpected result: hit %b read_value %h evicted %b", got.hit, got.read_value,
               got.evicted);
        errors++;
        return;
      end
      exp = pending_lookups.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %b, got %b", exp.hit, got.hit);
        errors++;
      end
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %h, got %h", exp.read_value, got.read_value);
        errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $error("evicted: expected %b, got %b", exp.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== exp.evicted_key) begin
        $error("evicted_key: expected %h, got %h", exp.evicted_key, got.evicted_key);
        errors++;
      end
      if (got.evicted_value !== exp.evicted_value) begin
        $error("evicted_value: expected %h, got %h", exp.evicted_value, got.evicted_value);
        errors++;
      end
    endfunction

    function void finish_check();
      if (pending_lookups.size() != 0) begin
        $error("%0d lookups never answered", pending_lookups.size());
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_data = '0;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  lru_cache_checker chk;
  logic [KEY_W-1:0] key_pool [16];
  int               phase_caps [12] = '{8, 1, 0, 3, 15, 2, 5, 9, 4, 6, 7, 8};

  lru_key_value_cache uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) chk.check_response(out_data);
  end

  function automatic in_item_t mk_item(logic act, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
    in_item_t it;
    it.action = act;
    it.key = k;
    it.value = v;
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return key_pool[$urandom_range(0, span - 1)];
    if (r < 85) return key_pool[$urandom_range(0, span - 1)] ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7fff_ffff;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    chk.note_request(it);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    in_data <= mk_item(1'($urandom_range(0, 1)), $urandom, $urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (chk.pending() > 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    cfg_wdata <= c;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.set_capacity(c);
  endtask

  task automatic run_phase(int n, int span, int gap_pct, int put_pct);
    logic act;
    for (int i = 6; i < 16; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(0, 99) < put_pct) ? ACT_PUT : ACT_GET;
      send_item(mk_item(act, pick_key(span), pick_value()));
      if ($urandom_range(0, 99) < gap_pct) pause($urandom_range(1, 15));
    end
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    chk = new();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h7fff_ffff;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'h0000_0001;
    key_pool[5] = 32'h5555_5555;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty cache, extreme keys and values, near-miss compare, update on hit
    send_item(mk_item(ACT_GET, 32'h0000_0000, 32'h0000_0000));
    send_item(mk_item(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000));
    send_item(mk_item(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff));
    send_item(mk_item(ACT_PUT, 32'h0000_0000, 32'hffff_ffff));
    send_item(mk_item(ACT_PUT, 32'hffff_ffff, 32'h0000_0000));
    send_item(mk_item(ACT_GET, 32'h7fff_ffff, 32'h0000_0000));
    send_item(mk_item(ACT_GET, 32'h7fff_fffe, 32'h0000_0000));
    send_item(mk_item(ACT_PUT, 32'h8000_0000, 32'h1234_5678));
    send_item(mk_item(ACT_GET, 32'h8000_0000, 32'h0000_0000));
    send_item(mk_item(ACT_GET, 32'hffff_ffff, 32'ha5a5_a5a5));
    // fill past capacity so the least recent entry goes
    for (int i = 1; i <= 5; i++) send_item(mk_item(ACT_PUT, i, 32'h1000_0000 + i));
    send_item(mk_item(ACT_GET, 32'h0000_0000, 32'h0000_0000));
    send_item(mk_item(ACT_PUT, 32'h0000_0006, 32'hdead_beef));
    // capacity dropped below occupancy
    settle();
    write_capacity(4'd1);
    send_item(mk_item(ACT_PUT, 32'h0000_0100, 32'h0000_0100));
    send_item(mk_item(ACT_GET, 32'h0000_0003, 32'h0000_0000));
    send_item(mk_item(ACT_PUT, 32'h0000_0200, 32'h0000_0200));
    // zero capacity acts as one, oversize acts as full
    settle();
    write_capacity(4'd0);
    send_item(mk_item(ACT_PUT, 32'h0000_0300, 32'hffff_fffe));
    send_item(mk_item(ACT_GET, 32'h0000_0300, 32'h0000_0000));
    settle();
    write_capacity(4'd15);
    send_item(mk_item(ACT_PUT, 32'h0000_0400, 32'h0000_0001));
    send_item(mk_item(ACT_GET, 32'h0000_0400, 32'h0000_0000));

    for (int p = 0; p < 12; p++) begin
      settle();
      write_capacity(CAP_W'(phase_caps[p]));
      run_phase(40, $urandom_range(2, 14),
                (p == 11 || p % 4 == 1) ? 0 : $urandom_range(15, 60),
                $urandom_range(35, 65));
    end

    settle();
    repeat (SLOTS + 8) @(posedge clk);
    chk.finish_check();
    $display("summary: %0d transfers (%0d get, %0d put), %0d hits, %0d evictions",
             chk.n_get + chk.n_put, chk.n_get, chk.n_put, chk.n_hit, chk.n_evict);
    $display("summary: %0d capacity writes across 0, 1, mid values and above 8",
             chk.n_cfg);
    if (chk.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/lkv_pkg.sv
design/lkv_store.sv
design/lkv_seq.sv
design/lru_key_value_cache.sv
dv/lru_key_value_cache_tb.sv
